// ----- src/ece_pkg.sv -----
// Shared types and constants for the EEPROM command engine.
package ece_pkg;

  localparam int unsigned DEPTH_DEF   = 128;
  localparam int unsigned ADDR_W      = 7;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_EWDS   = 3'd1,
    OP_EWEN   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_WRALL  = 3'd4,
    OP_ERASE  = 3'd5,
    OP_ERALL  = 3'd6,
    OP_RELOAD = 3'd7
  } ece_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_DONE
  } ece_state_t;

  typedef struct packed {
    logic              write_enabled;
    logic              ignored;
    logic [DATA_W-1:0] data_out;
  } ece_res_t;

endpackage

// ----- src/ece_ram.sv -----
// Byte-wide simple dual-port RAM holding the EEPROM cells, registered read.
module ece_ram
  import ece_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/eeprom_command_engine.sv -----
// EEPROM command engine top level: command sequencer around the cell RAM.
//
// Input beats carry one command each: in_tuser holds the opcode, in_tdata the
// byte address and the current data register value. Every accepted command
// yields exactly one output beat with the data register after the command,
// the refused flag and the write enable latch.
// Single-byte commands (read, write, erase, enable, disable, reload) issue the
// RAM read on the accepting edge; write and erase modify and write the cell
// back in ST_LOOK, and ST_DONE then loads the output register.
// Write all and erase all, when the latch is set, sweep the whole RAM as a
// read/write-back pipeline over the single read and single write port.
// Items are handled one at a time: in_tready is high only while the sequencer
// is idle, which also keeps read-modify-write accesses to the same cell from
// overlapping.
// After reset the engine runs a clearing pass that writes 0xFF to all DEPTH
// cells with in_tready low; the latch resets to disabled.
// The output register holds a result while out_tready is low and the engine
// still accepts the next command; a finished result then waits until the
// output register frees up.
module eeprom_command_engine
  import ece_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] address, [14:7] data_in
  input  logic [OP_W-1:0]        in_tuser,   // [2:0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [7:0] data_out, [8] ignored, [9] write_enabled
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_END = CW'(DEPTH);

  ece_state_t        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              wr_v_r, wr_v_nxt;
  logic [AW-1:0]     wr_idx_r, wr_idx_nxt;
  ece_op_t           op_r, op_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              rng_r, rng_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              erase_r, erase_nxt;
  logic              latch_r, latch_nxt;
  ece_res_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  ece_res_t          out_res_r, out_res_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  ece_op_t           in_op;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;
  logic              in_acc;
  logic              in_rng;
  logic              in_mod;
  logic              in_bulk;
  logic              sweeping;
  logic              out_free;

  assign in_op    = ece_op_t'(in_tuser);
  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_data  = in_tdata[ADDR_W +: DATA_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign in_rng   = 32'(in_addr) < DEPTH;
  assign in_mod   = (in_op == OP_WRITE) || (in_op == OP_WRALL) ||
                    (in_op == OP_ERASE) || (in_op == OP_ERALL);
  assign in_bulk  = (in_op == OP_WRALL) || (in_op == OP_ERALL);
  assign sweeping = (state_r == ST_INIT) || (state_r == ST_SWEEP);
  assign out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(ece_res_t))'(0), out_res_r};

  ece_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == CNT_END) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_bulk && latch_r) ? ST_SWEEP : ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        if (cnt_r == CNT_END) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_nxt       = cnt_r;
    wr_v_nxt      = 1'b0;
    wr_idx_nxt    = wr_idx_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    rng_nxt       = rng_r;
    data_nxt      = data_r;
    erase_nxt     = erase_r;
    latch_nxt     = latch_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_idx_r;
    mem_wdata     = erase_r ? ERASED_BYTE : (mem_rdata & data_r);
    mem_raddr     = sweeping ? cnt_r[AW-1:0] : AW'(in_addr);

    // sweep: read cell cnt, write it back in the following cycle
    if (sweeping && (cnt_r != CNT_END)) begin
      cnt_nxt    = cnt_r + CW'(1);
      wr_v_nxt   = 1'b1;
      wr_idx_nxt = cnt_r[AW-1:0];
    end
    if (wr_v_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          addr_nxt  = AW'(in_addr);
          rng_nxt   = in_rng;
          data_nxt  = in_data;
          erase_nxt = (in_op == OP_ERALL);
          cnt_nxt   = '0;
          if (in_op == OP_EWDS) latch_nxt = 1'b0;
          if (in_op == OP_EWEN) latch_nxt = 1'b1;
          res_nxt.data_out      = in_data;
          res_nxt.ignored       = in_mod && !latch_r;
          res_nxt.write_enabled = (in_op == OP_EWEN) ? 1'b1 :
                                  (in_op == OP_EWDS) ? 1'b0 : latch_r;
        end
      end
      ST_LOOK: begin
        if (op_r == OP_READ) begin
          res_nxt.data_out = rng_r ? mem_rdata : ERASED_BYTE;
        end
        if (latch_r && rng_r && ((op_r == OP_WRITE) || (op_r == OP_ERASE))) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = (op_r == OP_ERASE) ? ERASED_BYTE : (mem_rdata & data_r);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      wr_v_r      <= 1'b0;
      erase_r     <= 1'b1;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_v_r      <= wr_v_nxt;
      erase_r     <= erase_nxt;
      latch_r     <= latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r  <= wr_idx_nxt;
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    rng_r     <= rng_nxt;
    data_r    <= data_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("engine took a beat while a command is in flight");

  a_single_write_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && mem_we) |-> latch_r)
    else $error("cell written with write enable latch clear");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_tvalid && out_res_r == $past(res_r)))
    else $error("finished result not moved to output register");

  a_ewen_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_EWEN) |=> latch_r)
    else $error("enable command did not set the latch");

  a_no_write_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> (state_r == ST_INIT || state_r == ST_SWEEP || state_r == ST_DONE ||
                state_r == ST_IDLE))
    else $error("sweep write-back overlaps a single-byte write");

endmodule
